// File: design/lsc_pkg.sv
// Shared types, constants and helper functions for the line segment clipper.
// No dependencies; imported by lsc_step and line_segment_clipper_core.
`default_nettype none
package lsc_pkg;

  localparam int COORD_W        = 16;
  localparam int MAX_CLIP_STEPS = 4;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int DIV_BITS       = 4;                              // quotient bits per stage
  localparam int DIV_STAGES     = (PROD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W          = DIV_STAGES * DIV_BITS;
  localparam int REG_ADDR_W     = 4;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  localparam logic signed [COORD_W-1:0] WIN_LOW_RESET  = COORD_W'(100);
  localparam logic signed [COORD_W-1:0] WIN_HIGH_RESET = COORD_W'(400);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } window_t;

  typedef struct packed {
    coord_t     x1;
    coord_t     y1;
    coord_t     x2;
    coord_t     y2;
    logic [3:0] c1;
    logic [3:0] c2;
    logic       done;
    logic       acc;
  } seg_t;

  typedef struct packed {
    seg_t                 seg;
    logic                 active;
    logic                 move_first;
    logic                 horiz;      // moving onto top/bottom: y fixed, x interpolated
    coord_t               fixed;
    coord_t               base;
    logic                 neg;
    logic [COORD_W-1:0]   ma;
    logic [COORD_W-1:0]   mb;
    logic [COORD_W-1:0]   mc;
    logic [COORD_W:0]     rem;
    logic [DIV_W-1:0]     num;
    logic [DIV_W-1:0]     quot;
  } job_t;

  function automatic logic [3:0] region(coord_t x, coord_t y, window_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < w.left) c = c | CODE_LEFT;
    else if (x > w.right) c = c | CODE_RIGHT;
    if (y < w.bottom) c = c | CODE_BOTTOM;
    else if (y > w.top) c = c | CODE_TOP;
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] mag(diff_t d);
    diff_t n;
    n = -d;
    return d[DIFF_W-1] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  // DIV_BITS steps of restoring division
  function automatic job_t div_step(job_t j);
    job_t r;
    r = j;
    for (int i = 0; i < DIV_BITS; i++) begin
      r.rem  = {r.rem[COORD_W-1:0], r.num[DIV_W-1]};
      r.num  = {r.num[DIV_W-2:0], 1'b0};
      r.quot = {r.quot[DIV_W-2:0], 1'b0};
      if (r.rem >= {1'b0, r.mc}) begin
        r.rem     = r.rem - {1'b0, r.mc};
        r.quot[0] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/lsc_step.sv
// One clip step: edge select, multiply, pipelined divide, endpoint update.
// Depends on lsc_pkg.
`default_nettype none
module lsc_step
  import lsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire window_t win,
  input  wire logic    step_in_valid,
  input  wire seg_t    step_in,
  output logic         step_out_valid,
  output seg_t         step_out
);

  job_t dec;
  logic v0, v1;
  job_t j0, j1;
  logic vd [DIV_STAGES];
  job_t jd [DIV_STAGES];

  always_comb begin
    seg_t       s;
    logic [3:0] sel;
    diff_t      dx, dy, a, b, c;
    s   = step_in;
    dec = '0;
    sel = (s.c1 != 4'd0) ? s.c1 : s.c2;
    dx  = DIFF_W'(s.x2) - DIFF_W'(s.x1);
    dy  = DIFF_W'(s.y2) - DIFF_W'(s.y1);
    a   = dy;
    b   = DIFF_W'(win.right) - DIFF_W'(s.x1);
    c   = dx;
    dec.horiz = 1'b0;
    dec.fixed = win.right;
    dec.base  = s.y1;
    if ((sel & CODE_TOP) != 4'd0) begin
      dec.horiz = 1'b1;
      dec.fixed = win.top;
      dec.base  = s.x1;
      a = dx;
      b = DIFF_W'(win.top) - DIFF_W'(s.y1);
      c = dy;
    end else if ((sel & CODE_BOTTOM) != 4'd0) begin
      dec.horiz = 1'b1;
      dec.fixed = win.bottom;
      dec.base  = s.x1;
      a = dx;
      b = DIFF_W'(win.bottom) - DIFF_W'(s.y1);
      c = dy;
    end else if ((sel & CODE_RIGHT) == 4'd0) begin
      dec.fixed = win.left;
      b = DIFF_W'(win.left) - DIFF_W'(s.x1);
    end
    dec.move_first = (s.c1 != 4'd0);
    dec.neg = a[DIFF_W-1] ^ b[DIFF_W-1] ^ c[DIFF_W-1];
    dec.ma  = mag(a);
    dec.mb  = mag(b);
    dec.mc  = mag(c);
    dec.active = 1'b0;
    if (!s.done) begin
      if ((s.c1 | s.c2) == 4'd0) begin
        s.done = 1'b1;
        s.acc  = 1'b1;
      end else if ((s.c1 & s.c2) != 4'd0) begin
        s.done = 1'b1;
        s.acc  = 1'b0;
      end else begin
        dec.active = 1'b1;
      end
    end
    dec.seg = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) vd[i] <= 1'b0;
      step_out_valid <= 1'b0;
    end else if (en) begin
      v0 <= step_in_valid;
      v1 <= v0;
      vd[0] <= v1;
      for (int i = 1; i < DIV_STAGES; i++) vd[i] <= vd[i-1];
      step_out_valid <= vd[DIV_STAGES-1];
    end
  end

  job_t mul_next;
  always_comb begin
    logic [PROD_W-1:0] prod;
    // full-width product of the two magnitudes
    prod          = j0.ma * j0.mb;
    mul_next      = j0;
    mul_next.num  = DIV_W'(prod);
    mul_next.rem  = '0;
    mul_next.quot = '0;
  end

  seg_t fin_next;
  always_comb begin
    job_t                  j;
    logic signed [DIV_W+1:0] q, bse, r;
    coord_t                val;
    j   = jd[DIV_STAGES-1];
    q   = (j.mc == '0) ? '0 : $signed({2'b00, j.quot});
    bse = (DIV_W+2)'(j.base);
    r   = j.neg ? bse - q : bse + q;
    if (r[DIV_W+1:COORD_W-1] != {(DIV_W-COORD_W+3){r[DIV_W+1]}})
      val = r[DIV_W+1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    else
      val = r[COORD_W-1:0];
    fin_next = j.seg;
    if (j.active) begin
      if (j.move_first) begin
        fin_next.x1 = j.horiz ? val : j.fixed;
        fin_next.y1 = j.horiz ? j.fixed : val;
        fin_next.c1 = region(fin_next.x1, fin_next.y1, win);
      end else begin
        fin_next.x2 = j.horiz ? val : j.fixed;
        fin_next.y2 = j.horiz ? j.fixed : val;
        fin_next.c2 = region(fin_next.x2, fin_next.y2, win);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j0 <= dec;
      j1 <= mul_next;
      jd[0] <= div_step(j1);
      for (int i = 1; i < DIV_STAGES; i++) jd[i] <= div_step(jd[i-1]);
      step_out <= fin_next;
    end
  end

endmodule
`default_nettype wire

// File: design/line_segment_clipper_core.sv
// Top level of the Cohen-Sutherland line segment clipper: window registers,
// region-code entry stage, four lsc_step pipelines, output register. Uses lsc_pkg.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | start_x start_y end_x end_y
//   out     | out_valid/out_stall| accepted clipped_start_x/_y clipped_end_x/_y
//   cfg     | APB psel/penable   | paddr pwdata prdata, pready tied high
//
// One segment per cycle while out is not stalled; a segment passes the entry stage,
// the four chained clip steps, each with an 8-stage divider, and the output register.
// Synchronous reset clears all valid bits and loads the default window.
// A stalled result freezes the whole pipeline; in_stall follows it.
`default_nettype none
module line_segment_clipper_core
  import lsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [COORD_W-1:0] start_x,
  input  wire logic signed [COORD_W-1:0] start_y,
  input  wire logic signed [COORD_W-1:0] end_x,
  input  wire logic signed [COORD_W-1:0] end_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       accepted,
  output logic signed [COORD_W-1:0]  clipped_start_x,
  output logic signed [COORD_W-1:0]  clipped_start_y,
  output logic signed [COORD_W-1:0]  clipped_end_x,
  output logic signed [COORD_W-1:0]  clipped_end_y,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  window_t win;
  logic    en;
  logic    v_in;
  seg_t    s_in;
  logic    sv [MAX_CLIP_STEPS+1];
  seg_t    ss [MAX_CLIP_STEPS+1];

  assign pready   = 1'b1;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= WIN_LOW_RESET;
      win.bottom <= WIN_LOW_RESET;
      win.right  <= WIN_HIGH_RESET;
      win.top    <= WIN_HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LEFT:   win.left   <= pwdata[COORD_W-1:0];
        REG_BOTTOM: win.bottom <= pwdata[COORD_W-1:0];
        REG_RIGHT:  win.right  <= pwdata[COORD_W-1:0];
        REG_TOP:    win.top    <= pwdata[COORD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    coord_t r;
    unique case (paddr[3:2])
      REG_LEFT:   r = win.left;
      REG_BOTTOM: r = win.bottom;
      REG_RIGHT:  r = win.right;
      REG_TOP:    r = win.top;
      default:    r = '0;
    endcase
    prdata = 32'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_in      <= in_valid;
      out_valid <= sv[MAX_CLIP_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_in.x1   <= start_x;
      s_in.y1   <= start_y;
      s_in.x2   <= end_x;
      s_in.y2   <= end_y;
      s_in.c1   <= region(start_x, start_y, win);
      s_in.c2   <= region(end_x, end_y, win);
      s_in.done <= 1'b0;
      s_in.acc  <= 1'b0;
    end
  end

  assign sv[0] = v_in;
  assign ss[0] = s_in;

  for (genvar k = 0; k < MAX_CLIP_STEPS; k++) begin : g_step
    lsc_step u_step (
      .clk            (clk),
      .rst            (rst),
      .en             (en),
      .win            (win),
      .step_in_valid  (sv[k]),
      .step_in        (ss[k]),
      .step_out_valid (sv[k+1]),
      .step_out       (ss[k+1])
    );
  end

  // after the last step: accept only if already accepted or now fully inside
  always_ff @(posedge clk) begin
    if (en) begin
      logic f_acc;
      f_acc = ss[MAX_CLIP_STEPS].done ? ss[MAX_CLIP_STEPS].acc
                                      : ((ss[MAX_CLIP_STEPS].c1 | ss[MAX_CLIP_STEPS].c2) == 4'd0);
      accepted        <= f_acc;
      clipped_start_x <= f_acc ? ss[MAX_CLIP_STEPS].x1 : '0;
      clipped_start_y <= f_acc ? ss[MAX_CLIP_STEPS].y1 : '0;
      clipped_end_x   <= f_acc ? ss[MAX_CLIP_STEPS].x2 : '0;
      clipped_end_y   <= f_acc ? ss[MAX_CLIP_STEPS].y2 : '0;
    end
  end

endmodule
`default_nettype wire
